### design/rph_pkg.sv
// Shared types, widths and constants of the ray versus parallelepiped hit test.
`timescale 1ns / 1ps
`default_nettype none
package rph_pkg;

    localparam int REG_SLABS    = 3;
    localparam int NUM_SLABS_DEF = 3;
    localparam int POS_W        = 32;
    localparam int DIR_W        = 18;
    localparam int NV_W         = 18;
    localparam int REACH_W      = 31;
    localparam int FRAC_BITS    = 16;
    localparam int PO_W         = POS_W + NV_W;
    localparam int PU_W         = DIR_W + NV_W;
    localparam int PN_W         = PO_W + 2;
    localparam int UN_W         = PU_W + 2;
    localparam int OFF_W        = POS_W + FRAC_BITS;
    localparam int DIFF_W       = PN_W + 1;
    localparam int A_W          = DIFF_W;
    localparam int B_W          = UN_W;
    localparam int QBITS        = 60;
    localparam int CAP_SHIFT    = QBITS - FRAC_BITS;
    localparam int T_W          = QBITS + 2;
    localparam int DIV_LAT      = QBITS + 2;
    localparam int PP_W         = DIR_W + REACH_W + 1;
    localparam int IN_W         = 184;
    localparam int OUT_W        = 128;
    localparam int USER_W       = 2;
    localparam int CFG_W        = 64;
    localparam int ADDR_W       = 6;
    localparam int NORM_W       = 3 * NV_W;

    localparam logic signed [T_W-1:0] DIST_CAP   = T_W'(64'sh1000_0000_0000_0000);
    localparam logic signed [T_W-1:0] FRONT_INIT = -DIST_CAP - T_W'(1);
    localparam logic signed [T_W-1:0] BACK_INIT  = DIST_CAP + T_W'(1);

    typedef enum logic [2:0] {
        REG_NORMAL_FB = 3'd0,
        REG_NORMAL_TB = 3'd1,
        REG_NORMAL_LR = 3'd2,
        REG_BOUNDS_FB = 3'd3,
        REG_BOUNDS_TB = 3'd4,
        REG_BOUNDS_LR = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [2:0][POS_W-1:0] org;
        logic [2:0][DIR_W-1:0] dir;
        logic [REACH_W-1:0]    reach;
    } item_t;

    typedef struct packed {
        logic near_en;
        logic un_zero;
        logic srej;
    } flag_t;

    typedef struct packed {
        logic signed [T_W-1:0] t_near;
        logic signed [T_W-1:0] t_far;
        flag_t                 flags;
    } slab_t;

    typedef struct packed {
        logic                  rej;
        logic signed [T_W-1:0] front;
        logic signed [T_W-1:0] back;
    } run_t;

endpackage
`default_nettype wire

### design/rph_cfg.sv
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps
`default_nettype none
module rph_cfg (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [rph_pkg::ADDR_W-1:0]             paddr,
    input  logic [rph_pkg::CFG_W-1:0]              pwdata,
    output logic [rph_pkg::CFG_W-1:0]              prdata,
    output logic [rph_pkg::NORM_W-1:0]             normals [rph_pkg::REG_SLABS],
    output logic [rph_pkg::CFG_W-1:0]              bounds  [rph_pkg::REG_SLABS]
);
    import rph_pkg::*;

    logic [NORM_W-1:0] normal_reg [REG_SLABS];
    logic [CFG_W-1:0]  bound_reg  [REG_SLABS];
    reg_idx_t          idx;
    logic              wr;

    assign idx = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_SLABS; i++) begin
                normal_reg[i] <= '0;
                bound_reg[i]  <= '0;
            end
        end else if (wr) begin
            unique case (idx)
                REG_NORMAL_FB: normal_reg[0] <= pwdata[NORM_W-1:0];
                REG_NORMAL_TB: normal_reg[1] <= pwdata[NORM_W-1:0];
                REG_NORMAL_LR: normal_reg[2] <= pwdata[NORM_W-1:0];
                REG_BOUNDS_FB: bound_reg[0]  <= pwdata;
                REG_BOUNDS_TB: bound_reg[1]  <= pwdata;
                REG_BOUNDS_LR: bound_reg[2]  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_NORMAL_FB: prdata = CFG_W'(normal_reg[0]);
            REG_NORMAL_TB: prdata = CFG_W'(normal_reg[1]);
            REG_NORMAL_LR: prdata = CFG_W'(normal_reg[2]);
            REG_BOUNDS_FB: prdata = bound_reg[0];
            REG_BOUNDS_TB: prdata = bound_reg[1];
            REG_BOUNDS_LR: prdata = bound_reg[2];
            default:       prdata = '0;
        endcase
    end

    assign normals = normal_reg;
    assign bounds  = bound_reg;

endmodule
`default_nettype wire

### design/rph_div.sv
// Pipelined restoring divider giving a saturated signed Q46.16 distance.
`timescale 1ns / 1ps
`default_nettype none
module rph_div (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [rph_pkg::A_W-1:0]           a,
    input  logic [rph_pkg::B_W-1:0]           b,
    input  logic                              neg,
    output logic signed [rph_pkg::T_W-1:0]    t
);
    import rph_pkg::*;

    logic [B_W-1:0]   rem_reg [QBITS+1];
    logic [A_W-1:0]   a_reg   [QBITS];
    logic [B_W-1:0]   b_reg   [QBITS+1];
    logic [QBITS-1:0] q_reg   [QBITS+1];
    logic             cap_reg [QBITS+1];
    logic             neg_reg [QBITS+1];
    logic signed [T_W-1:0] mag;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= B_W'(a >> CAP_SHIFT);
            cap_reg[0] <= (a >> CAP_SHIFT) >= A_W'(b);
            a_reg[0]   <= a;
            b_reg[0]   <= b;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
        end
    end

    for (genvar i = 1; i <= QBITS; i++) begin : g_step
        localparam int J = QBITS - i;
        logic           nbit;
        logic [B_W:0]   trial;
        logic           ge;

        if (J >= FRAC_BITS) begin : g_bit
            assign nbit = a_reg[i-1][J-FRAC_BITS];
        end else begin : g_zero
            assign nbit = 1'b0;
        end

        assign trial = {rem_reg[i-1], nbit};
        assign ge    = trial >= {1'b0, b_reg[i-1]};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= ge ? B_W'(trial - {1'b0, b_reg[i-1]}) : trial[B_W-1:0];
                b_reg[i]    <= b_reg[i-1];
                q_reg[i]    <= q_reg[i-1] | (QBITS'(ge) << J);
                cap_reg[i]  <= cap_reg[i-1];
                neg_reg[i]  <= neg_reg[i-1];
            end
        end

        if (i < QBITS) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    a_reg[i] <= a_reg[i-1];
                end
            end
        end
    end

    assign mag = cap_reg[QBITS] ? DIST_CAP : $signed(T_W'(q_reg[QBITS]));

    always_ff @(posedge aclk) begin
        if (en) begin
            t <= neg_reg[QBITS] ? -mag : mag;
        end
    end

endmodule
`default_nettype wire

### design/rph_slab.sv
// One slab step: narrows the entry/exit interval and flags a reject.
`timescale 1ns / 1ps
`default_nettype none
module rph_slab #(
    parameter int NSLAB = rph_pkg::REG_SLABS,
    parameter int IDX   = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  rph_pkg::item_t  in_item,
    input  rph_pkg::run_t   in_run,
    input  rph_pkg::slab_t  in_slab [NSLAB],
    output logic            out_valid,
    output rph_pkg::item_t  out_item,
    output rph_pkg::run_t   out_run,
    output rph_pkg::slab_t  out_slab [NSLAB]
);
    import rph_pkg::*;

    logic                  valid_reg;
    item_t                 item_reg;
    run_t                  run_reg;
    run_t                  run_next;
    slab_t                 slab_reg [NSLAB];
    slab_t                 cur;
    logic signed [T_W-1:0] reach_t;

    assign cur     = in_slab[IDX];
    assign reach_t = $signed(T_W'(in_item.reach));

    always_comb begin
        run_next = in_run;
        if (!in_run.rej) begin
            if (cur.flags.srej) begin
                run_next.rej = 1'b1;
            end else if (!cur.flags.un_zero) begin
                if (cur.flags.near_en && cur.t_near > in_run.front) begin
                    if (cur.t_near > in_run.back || cur.t_near > reach_t) begin
                        run_next.rej = 1'b1;
                    end else begin
                        run_next.front = cur.t_near;
                    end
                end
                if (!run_next.rej && cur.t_far < run_next.back) begin
                    if (cur.t_far < run_next.front) begin
                        run_next.rej = 1'b1;
                    end else begin
                        run_next.back = cur.t_far;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= in_item;
            run_reg  <= run_next;
            slab_reg <= in_slab;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_run   = run_reg;
    assign out_slab  = slab_reg;

endmodule
`default_nettype wire

### design/rph_point.sv
// Hit point stages: direction times distance, then offset and saturation.
`timescale 1ns / 1ps
`default_nettype none
module rph_point (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  rph_pkg::item_t                      in_item,
    input  logic [rph_pkg::REACH_W-1:0]         alpha,
    input  logic                                outside,
    output logic                                m_tvalid,
    output logic [rph_pkg::OUT_W-1:0]           m_tdata,
    output logic [rph_pkg::USER_W-1:0]          m_tuser
);
    import rph_pkg::*;

    localparam int SH_W  = PP_W - FRAC_BITS;
    localparam int SUM_W = SH_W + 1;

    logic                    v1_reg;
    logic signed [PP_W-1:0]  prod_reg [3];
    logic [2:0][POS_W-1:0]   org_reg;
    logic [REACH_W-1:0]      alpha_reg;
    logic                    outside_reg;
    logic [PP_W-1:0]         pmag [3];
    logic [SH_W-1:0]         shm  [3];
    logic signed [SH_W-1:0]  dlt  [3];
    logic signed [SUM_W-1:0] sum  [3];
    logic [2:0][POS_W-1:0]   pt;

    logic                    valid_reg;
    logic [OUT_W-1:0]        data_reg;
    logic [USER_W-1:0]       user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                prod_reg[k] <= $signed(in_item.dir[k]) * $signed({1'b0, alpha});
            end
            org_reg     <= in_item.org;
            alpha_reg   <= alpha;
            outside_reg <= outside;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pmag[k] = prod_reg[k][PP_W-1] ? PP_W'(-prod_reg[k]) : PP_W'(prod_reg[k]);
            shm[k]  = SH_W'(pmag[k] >> FRAC_BITS);
            dlt[k]  = prod_reg[k][PP_W-1] ? -$signed(shm[k]) : $signed(shm[k]);
            sum[k]  = SUM_W'($signed(org_reg[k])) + SUM_W'(dlt[k]);
            if (sum[k] > SUM_W'(64'sh7FFF_FFFF)) begin
                pt[k] = 32'h7FFF_FFFF;
            end else if (sum[k] < -SUM_W'(64'sh8000_0000)) begin
                pt[k] = 32'h8000_0000;
            end else begin
                pt[k] = sum[k][POS_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= {1'b0, pt[2], pt[1], pt[0], alpha_reg};
            user_reg <= {outside_reg, 1'b1};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule
`default_nettype wire

### design/ray_parallelepiped_hit.sv
// Top level: ray versus parallelepiped hit test over configured slabs.
// Throughput is one ray per cycle while m_tready does not stall the output;
// the long pipelined divider sets the latency. Rays that miss produce no result
// word. Reset is synchronous and active low; it clears all valid bits and the
// configuration registers.
`timescale 1ns / 1ps
`default_nettype none
module ray_parallelepiped_hit #(
    parameter int NUM_SLABS = rph_pkg::NUM_SLABS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, reach_limit, zero fill.
    input  logic [rph_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit_distance, point_x, point_y, point_z, zero fill.
    output logic [rph_pkg::OUT_W-1:0]     m_tdata,
    // hit, from_outside.
    output logic [rph_pkg::USER_W-1:0]    m_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rph_pkg::ADDR_W-1:0]    paddr,
    input  logic [rph_pkg::CFG_W-1:0]     pwdata,
    output logic [rph_pkg::CFG_W-1:0]     prdata,
    output logic                          pready
);
    import rph_pkg::*;

    localparam int ACTIVE = (NUM_SLABS < REG_SLABS) ? NUM_SLABS : REG_SLABS;

    logic [NORM_W-1:0] normals [REG_SLABS];
    logic [CFG_W-1:0]  bounds  [REG_SLABS];
    logic              en;
    item_t             item_in;

    rph_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .normals (normals),
        .bounds  (bounds)
    );

    assign pready   = 1'b1;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign item_in.org[0] = s_tdata[31:0];
    assign item_in.org[1] = s_tdata[63:32];
    assign item_in.org[2] = s_tdata[95:64];
    assign item_in.dir[0] = s_tdata[113:96];
    assign item_in.dir[1] = s_tdata[131:114];
    assign item_in.dir[2] = s_tdata[149:132];
    assign item_in.reach  = s_tdata[180:150];

    // Stage 1: products.
    logic                   v1_reg;
    item_t                  it1_reg;
    logic signed [PO_W-1:0] po1_reg [ACTIVE][3];
    logic signed [PU_W-1:0] pu1_reg [ACTIVE][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it1_reg <= item_in;
            for (int s = 0; s < ACTIVE; s++) begin
                for (int k = 0; k < 3; k++) begin
                    po1_reg[s][k] <= $signed(item_in.org[k]) *
                                     $signed(normals[s][NV_W*k +: NV_W]);
                    pu1_reg[s][k] <= $signed(item_in.dir[k]) *
                                     $signed(normals[s][NV_W*k +: NV_W]);
                end
            end
        end
    end

    // Stage 2: dot products.
    logic                   v2_reg;
    item_t                  it2_reg;
    logic signed [PN_W-1:0] pn2_reg [ACTIVE];
    logic signed [UN_W-1:0] un2_reg [ACTIVE];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it2_reg <= it1_reg;
            for (int s = 0; s < ACTIVE; s++) begin
                pn2_reg[s] <= PN_W'(po1_reg[s][0]) + PN_W'(po1_reg[s][1]) +
                              PN_W'(po1_reg[s][2]);
                un2_reg[s] <= UN_W'(pu1_reg[s][0]) + UN_W'(pu1_reg[s][1]) +
                              UN_W'(pu1_reg[s][2]);
            end
        end
    end

    // Stage 3: plane tests and divider operands.
    logic                     v3_reg;
    item_t                    it3_reg;
    flag_t                    fl3_reg  [ACTIVE];
    logic [A_W-1:0]           an3_reg  [ACTIVE];
    logic [A_W-1:0]           af3_reg  [ACTIVE];
    logic [B_W-1:0]           b3_reg   [ACTIVE];
    logic                     nn3_reg  [ACTIVE];
    logic                     nf3_reg  [ACTIVE];

    logic signed [OFF_W-1:0]  top_off  [ACTIVE];
    logic signed [OFF_W-1:0]  bot_off  [ACTIVE];
    logic signed [DIFF_W-1:0] dn       [ACTIVE];
    logic signed [DIFF_W-1:0] df       [ACTIVE];
    logic                     un_pos   [ACTIVE];
    logic                     un_zero  [ACTIVE];
    logic                     above    [ACTIVE];
    logic                     below    [ACTIVE];

    always_comb begin
        for (int s = 0; s < ACTIVE; s++) begin
            top_off[s] = $signed({bounds[s][63:32], {FRAC_BITS{1'b0}}});
            bot_off[s] = $signed({bounds[s][31:0], {FRAC_BITS{1'b0}}});
            un_zero[s] = un2_reg[s] == '0;
            un_pos[s]  = !un2_reg[s][UN_W-1] && !un_zero[s];
            above[s]   = PN_W'(top_off[s]) < pn2_reg[s];
            below[s]   = pn2_reg[s] < PN_W'(bot_off[s]);
            dn[s] = DIFF_W'(un_pos[s] ? bot_off[s] : top_off[s]) - DIFF_W'(pn2_reg[s]);
            df[s] = DIFF_W'(un_pos[s] ? top_off[s] : bot_off[s]) - DIFF_W'(pn2_reg[s]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it3_reg <= it2_reg;
            for (int s = 0; s < ACTIVE; s++) begin
                fl3_reg[s].un_zero <= un_zero[s];
                fl3_reg[s].srej    <= un_zero[s] ? (above[s] || below[s]) :
                                      (un_pos[s] ? above[s] : below[s]);
                fl3_reg[s].near_en <= un_pos[s] ? !dn[s][DIFF_W-1] :
                                      (dn[s][DIFF_W-1] || dn[s] == '0);
                an3_reg[s] <= dn[s][DIFF_W-1] ? A_W'(-dn[s]) : A_W'(dn[s]);
                af3_reg[s] <= df[s][DIFF_W-1] ? A_W'(-df[s]) : A_W'(df[s]);
                b3_reg[s]  <= un2_reg[s][UN_W-1] ? B_W'(-un2_reg[s]) : B_W'(un2_reg[s]);
                nn3_reg[s] <= dn[s][DIFF_W-1] ^ un2_reg[s][UN_W-1];
                nf3_reg[s] <= df[s][DIFF_W-1] ^ un2_reg[s][UN_W-1];
            end
        end
    end

    // Dividers and the matching delay line.
    logic signed [T_W-1:0] tn [ACTIVE];
    logic signed [T_W-1:0] tf [ACTIVE];

    for (genvar s = 0; s < ACTIVE; s++) begin : g_div
        rph_div u_div_near (
            .aclk (aclk),
            .en   (en),
            .a    (an3_reg[s]),
            .b    (b3_reg[s]),
            .neg  (nn3_reg[s]),
            .t    (tn[s])
        );
        rph_div u_div_far (
            .aclk (aclk),
            .en   (en),
            .a    (af3_reg[s]),
            .b    (b3_reg[s]),
            .neg  (nf3_reg[s]),
            .t    (tf[s])
        );
    end

    logic  vd_reg  [DIV_LAT];
    item_t itd_reg [DIV_LAT];
    flag_t fld_reg [DIV_LAT][ACTIVE];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                vd_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vd_reg[0] <= v3_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                vd_reg[i] <= vd_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            itd_reg[0] <= it3_reg;
            fld_reg[0] <= fl3_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                itd_reg[i] <= itd_reg[i-1];
                fld_reg[i] <= fld_reg[i-1];
            end
        end
    end

    // Slab chain, one stage per slab.
    logic  vc  [ACTIVE+1];
    item_t itc [ACTIVE+1];
    run_t  rc  [ACTIVE+1];
    slab_t sc  [ACTIVE+1][ACTIVE];

    assign vc[0]        = vd_reg[DIV_LAT-1];
    assign itc[0]       = itd_reg[DIV_LAT-1];
    assign rc[0].rej    = 1'b0;
    assign rc[0].front  = FRONT_INIT;
    assign rc[0].back   = BACK_INIT;

    for (genvar s = 0; s < ACTIVE; s++) begin : g_slab_in
        assign sc[0][s].t_near = tn[s];
        assign sc[0][s].t_far  = tf[s];
        assign sc[0][s].flags  = fld_reg[DIV_LAT-1][s];
    end

    for (genvar s = 0; s < ACTIVE; s++) begin : g_slab
        rph_slab #(
            .NSLAB (ACTIVE),
            .IDX   (s)
        ) u_slab (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (vc[s]),
            .in_item   (itc[s]),
            .in_run    (rc[s]),
            .in_slab   (sc[s]),
            .out_valid (vc[s+1]),
            .out_item  (itc[s+1]),
            .out_run   (rc[s+1]),
            .out_slab  (sc[s+1])
        );
    end

    // Final choice of face and distance; misses leave the pipeline here.
    logic                  vf_reg;
    item_t                 itf_reg;
    logic [REACH_W-1:0]    alpha_reg;
    logic                  outside_reg;
    logic signed [T_W-1:0] reach_f;
    logic                  front_hit;
    logic                  back_hit;
    run_t                  rl;

    assign rl        = rc[ACTIVE];
    assign reach_f   = $signed(T_W'(itc[ACTIVE].reach));
    assign front_hit = rl.front > 0;
    assign back_hit  = rl.back > 0 && rl.back < reach_f;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf_reg <= 1'b0;
        end else if (en) begin
            vf_reg <= vc[ACTIVE] && !rl.rej && (front_hit || back_hit);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            itf_reg     <= itc[ACTIVE];
            alpha_reg   <= front_hit ? rl.front[REACH_W-1:0] : rl.back[REACH_W-1:0];
            outside_reg <= front_hit;
        end
    end

    rph_point u_point (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (vf_reg),
        .in_item  (itf_reg),
        .alpha    (alpha_reg),
        .outside  (outside_reg),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

### design/rph_checker.sv
// Port-level checker for the hit test block and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module rph_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rph_pkg::OUT_W-1:0]     m_tdata,
    input logic [rph_pkg::USER_W-1:0]    m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[0])
        else $error("result word without hit");

    a_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[30:0] != 31'd0)
        else $error("hit with zero distance");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output side");

endmodule

bind ray_parallelepiped_hit rph_checker u_rph_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

### bench/tb_top.sv
// Self-checking testbench for ray_parallelepiped_hit: rays against configured slabs.
`timescale 1ns / 1ps
module tb_top;
    import rph_pkg::*;

    typedef struct {
        logic signed [31:0] org [3];
        logic signed [17:0] dir [3];
        logic [30:0]        reach;
    } ray_t;

    typedef struct {
        bit                 hit;
        bit                 outside;
        logic [30:0]        distance;
        logic signed [31:0] pt [3];
    } hit_t;

    class hit_scoreboard;
        logic [53:0] normals [3];
        logic [63:0] bounds [3];
        hit_t        pending [$];
        int          errors;

        function new();
            for (int i = 0; i < 3; i++) begin
                normals[i] = '0;
                bounds[i] = '0;
            end
            errors = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [63:0] value);
            if (idx <= REG_NORMAL_LR) begin
                normals[idx] = value[53:0];
            end else begin
                bounds[idx - REG_BOUNDS_FB] = value;
            end
        endfunction

        // Signed quotient of two Q.32 values in Q46.16, truncated and capped.
        function longint slab_dist(longint num, longint den);
            longint unsigned a, b, q, r, t;
            longint mag;
            bit neg;
            neg = (num < 0) != (den < 0);
            a = num < 0 ? -num : num;
            b = den < 0 ? -den : den;
            q = a / b;
            r = a % b;
            if (q >= (64'd1 << 44)) begin
                mag = 64'sd1 <<< 60;
            end else begin
                t = (q << 16) + ((r << 16) / b);
                mag = t > (64'd1 << 60) ? (64'sd1 <<< 60) : longint'(t);
            end
            return neg ? -mag : mag;
        endfunction

        function bit trace(ray_t r, output hit_t h);
            longint org [3], dir [3];
            longint cap, front, back, alpha, pn, un, top, bot, nv, near_off, far_off, t, p, d;
            bit outside;
            h.hit = 0; h.outside = 0; h.distance = '0;
            for (int k = 0; k < 3; k++) h.pt[k] = '0;
            cap = 64'sd1 <<< 60;
            front = -(cap + 1);
            back = cap + 1;
            for (int k = 0; k < 3; k++) begin
                org[k] = r.org[k];
                dir[k] = r.dir[k];
            end
            for (int s = 0; s < 3; s++) begin
                pn = 0;
                un = 0;
                for (int k = 0; k < 3; k++) begin
                    nv = longint'($signed(normals[s][18*k +: 18]));
                    pn += org[k] * nv;
                    un += dir[k] * nv;
                end
                top = longint'($signed(bounds[s][63:32])) * 65536;
                bot = longint'($signed(bounds[s][31:0])) * 65536;
                if (un != 0) begin
                    near_off = un > 0 ? bot : top;
                    far_off = un > 0 ? top : bot;
                    if (un > 0 ? (pn > top) : (pn < bot)) return 0;
                    if (un > 0 ? (near_off - pn >= 0) : (near_off - pn <= 0)) begin
                        t = slab_dist(near_off - pn, un);
                        if (t > front) begin
                            if (t > back || t > longint'(r.reach)) return 0;
                            front = t;
                        end
                    end
                    t = slab_dist(far_off - pn, un);
                    if (t < back) begin
                        if (t < front) return 0;
                        back = t;
                    end
                end else if (pn < bot || pn > top) begin
                    return 0;
                end
            end
            if (front > 0) begin
                alpha = front;
                outside = 1;
            end else if (back > 0 && back < longint'(r.reach)) begin
                alpha = back;
                outside = 0;
            end else begin
                return 0;
            end
            h.hit = 1;
            h.outside = outside;
            h.distance = alpha[30:0];
            for (int k = 0; k < 3; k++) begin
                p = dir[k] * alpha;
                d = p < 0 ? -((-p) >>> 16) : (p >>> 16);
                d = org[k] + d;
                if (d > 64'sd2147483647) d = 64'sd2147483647;
                if (d < -64'sd2147483648) d = -64'sd2147483648;
                h.pt[k] = d[31:0];
            end
            return 1;
        endfunction

        function void note_ray(ray_t r);
            hit_t h;
            if (trace(r, h)) pending.push_back(h);
        endfunction

        function void check_hit(hit_t a);
            hit_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word distance=%h", $time, a.distance);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.hit !== e.hit) begin
                $display("%0t: hit expected %b actual %b", $time, e.hit, a.hit);
                errors++;
            end
            if (a.outside !== e.outside) begin
                $display("%0t: from_outside expected %b actual %b", $time, e.outside, a.outside);
                errors++;
            end
            if (a.distance !== e.distance) begin
                $display("%0t: hit_distance expected %h actual %h", $time, e.distance,
                         a.distance);
                errors++;
            end
            for (int k = 0; k < 3; k++) begin
                if (a.pt[k] !== e.pt[k]) begin
                    $display("%0t: point[%0d] expected %h actual %h", $time, k, e.pt[k],
                             a.pt[k]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic [USER_W-1:0]    m_tuser;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [CFG_W-1:0]     pwdata;
    logic [CFG_W-1:0]     prdata;
    logic                 pready;

    hit_scoreboard sb;
    int  max_gap_in;
    int  max_gap_out;
    longint cycles;

    ray_parallelepiped_hit dut (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [63:0] value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= ADDR_W'(8 * int'(idx));
        pwdata <= value;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.set_reg(idx, value);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic send_ray(ray_t r);
        int gap;
        gap = $urandom_range(0, max_gap_in);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {3'b0, r.reach, r.dir[2], r.dir[1], r.dir[0],
                    r.org[2], r.org[1], r.org[0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_ray(r);
    endtask

    function automatic ray_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz, int rch);
        ray_t r;
        r.org[0] = ox; r.org[1] = oy; r.org[2] = oz;
        r.dir[0] = dx; r.dir[1] = dy; r.dir[2] = dz;
        r.reach = rch[30:0];
        return r;
    endfunction

    function automatic ray_t noise_ray();
        ray_t r;
        for (int k = 0; k < 3; k++) begin
            r.org[k] = $urandom;
            r.dir[k] = $urandom;
        end
        r.reach = $urandom;
        return r;
    endfunction

    // Aims a ray through a random point of a box with half size h units.
    function automatic ray_t aimed_ray(int h);
        ray_t r;
        int target, d, k;
        k = $urandom_range(0, 40);
        for (int i = 0; i < 3; i++) begin
            target = $urandom_range(0, 2 * h * 65536) - h * 65536;
            d = $urandom_range(0, 131072) - 65536;
            r.dir[i] = d;
            r.org[i] = target - d * k;
        end
        case ($urandom_range(0, 3))
            0: r.reach = 31'h7FFFFFFF;
            1: r.reach = $urandom_range(0, 65536 * 8);
            default: r.reach = $urandom_range(0, 65536 * 100);
        endcase
        return r;
    endfunction

    task automatic axis_box(int h, bit swap);
        logic [31:0] up, lo;
        up = h * 65536;
        lo = -h * 65536;
        write_reg(REG_NORMAL_FB, 64'd65536);
        write_reg(REG_NORMAL_TB, 64'd65536 << 18);
        write_reg(REG_NORMAL_LR, 64'd65536 << 36);
        write_reg(REG_BOUNDS_FB, swap ? {lo, up} : {up, lo});
        write_reg(REG_BOUNDS_TB, {up, lo});
        write_reg(REG_BOUNDS_LR, {up, lo});
    endtask

    task automatic random_run(int n, int h, int aimed_pct);
        for (int i = 0; i < n; i++) begin
            if (i % 150 == 0) max_gap_in = ($urandom_range(0, 2) == 0) ? 0 : 12;
            if ($urandom_range(0, 99) < aimed_pct) send_ray(aimed_ray(h));
            else send_ray(noise_ray());
        end
    endtask

    initial begin
        hit_t a;
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            gap = $urandom_range(0, max_gap_out);
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            a.hit = m_tuser[0];
            a.outside = m_tuser[1];
            a.distance = m_tdata[30:0];
            a.pt[0] = m_tdata[62:31];
            a.pt[1] = m_tdata[94:63];
            a.pt[2] = m_tdata[126:95];
            sb.check_hit(a);
        end
    end

    always @(posedge aclk) begin
        if (cycles % 3000 == 0) max_gap_out <= ($urandom_range(0, 2) == 0) ? 0 : 12;
    end

    initial begin
        int t10, big;
        sb = new();
        cycles = 0;
        max_gap_in = 12;
        max_gap_out = 12;
        aresetn <= 0;
        s_tvalid <= 0;
        s_tdata <= '0;
        m_tready <= 0;
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        paddr <= '0;
        pwdata <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        random_run(20, 10, 50);
        drain();

        axis_box(10, 0);
        t10 = 10 * 65536;
        big = 32'h7FFFFFFF;
        send_ray(mk_ray(-2 * t10, 0, 0, 65536, 0, 0, big));
        send_ray(mk_ray(0, 0, 0, 65536, 0, 0, big));
        send_ray(mk_ray(0, 0, 0, -65536, 0, 0, big));
        send_ray(mk_ray(-2 * t10, 0, 0, 65536, 0, 0, t10));
        send_ray(mk_ray(-2 * t10, 0, 0, 65536, 0, 0, 0));
        send_ray(mk_ray(0, 2 * t10, 0, 65536, 0, 0, big));
        send_ray(mk_ray(0, 65536, 0, 65536, 0, 0, big));
        send_ray(mk_ray(0, 0, 0, 0, 0, 0, big));
        send_ray(mk_ray(0, 0, -2 * t10, -131072, 131071, 65536, big));
        send_ray(mk_ray(-32'sh80000000, 0, 0, 131071, 0, 0, big));
        send_ray(mk_ray(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                        -131072, -131072, -131072, big));
        send_ray(mk_ray(t10, t10, t10, 65536, 65536, 65536, big));
        send_ray(mk_ray(-t10, -t10, -t10, 46341, 46341, 46341, big));
        send_ray(mk_ray(2 * t10, 0, 0, -65536, 0, 0, t10));
        send_ray(mk_ray(0, -2 * t10, 0, 0, 65536, 0, big));
        random_run(300, 10, 85);

        // Pause until every outstanding result has returned.
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        random_run(200, 10, 85);
        drain();

        axis_box(3, 1);
        random_run(200, 3, 85);
        drain();

        write_reg(REG_NORMAL_FB, {18'd0, 18'd46341, 18'd46341});
        write_reg(REG_NORMAL_TB, {18'd46341, 18'd0, -18'sd46341});
        write_reg(REG_NORMAL_LR, {-18'sd46341, 18'd46341, 18'd0});
        write_reg(REG_BOUNDS_FB, {32'sd8 * 65536, -32'sd8 * 65536});
        write_reg(REG_BOUNDS_TB, {32'sd8 * 65536, -32'sd8 * 65536});
        write_reg(REG_BOUNDS_LR, {32'sd8 * 65536, -32'sd8 * 65536});
        random_run(250, 5, 85);
        drain();

        for (int i = 0; i < 3; i++) begin
            write_reg(reg_idx_t'(i), {$urandom, $urandom});
            write_reg(reg_idx_t'(i + 3), {$urandom, $urandom});
        end
        random_run(200, 10, 60);
        drain();

        write_reg(REG_NORMAL_FB, {3{18'h1FFFF}});
        write_reg(REG_NORMAL_TB, {3{18'h20000}});
        write_reg(REG_NORMAL_LR, {18'h3FFFF, 18'h20000, 18'h1FFFF});
        write_reg(REG_BOUNDS_FB, {32'h7FFFFFFF, 32'h80000000});
        write_reg(REG_BOUNDS_TB, {32'h7FFFFFFF, 32'h80000000});
        write_reg(REG_BOUNDS_LR, 64'hFFFFFFFF_FFFFFFFF);
        random_run(200, 10, 60);

        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
